### sv/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the lfu cache table: field widths, default
// sizes, request codes, controller states and the scan result flags.
// ----------------------------------------------------------------------------
package lfu_pkg;

    // default sizing
    localparam int LFU_MAX_ENTRIES = 16;
    localparam int LFU_COUNT_BITS  = 16;

    // fixed field widths
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int STAMP_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // request codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WB
    } t_state;

    // what the scan found
    typedef struct packed {
        logic match_found;
        logic best_found;
        logic free_found;
    } t_scan_flags;

endpackage

### sv/lfu_cache_table.sv
// An accepted request is scanned over every entry through the single read port
// of the entry memory, then written back and its result registered; the write-back
// waits while the output is stalled. One request is worked on at a time, and no
// new request is taken until the block is idle again.
// Reset clears the valid bits, the touch counter and the output valid bit and
// sets capacity to 16; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key-value cache with least-frequently-used eviction and oldest-touch tie
// break. Entries live in one memory; each request scans it, then writes back on a hit or an insert.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
    parameter int  MAX_ENTRIES = lfu_pkg::LFU_MAX_ENTRIES,
    parameter int  COUNT_BITS  = lfu_pkg::LFU_COUNT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [lfu_pkg::KEY_W-1:0]   i_key,
    input  logic [lfu_pkg::VAL_W-1:0]   i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic [lfu_pkg::VAL_W-1:0]   o_read_value,
    output logic                        o_evicted,
    output logic [lfu_pkg::KEY_W-1:0]   o_evicted_key
);
    import lfu_pkg::*;

    localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int USED_W    = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W     = (USED_W > CAP_W) ? USED_W : CAP_W;
    localparam int STAMP_LSB = 0;
    localparam int COUNT_LSB = STAMP_LSB + STAMP_W;
    localparam int VALUE_LSB = COUNT_LSB + COUNT_BITS;
    localparam int KEY_LSB   = VALUE_LSB + VAL_W;
    localparam int WORD_W    = KEY_LSB + KEY_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    // controller and request registers
    t_state               r_state;
    t_state               n_state;
    logic [CAP_W-1:0]     r_cap;
    logic                 r_req_type;
    logic [KEY_W-1:0]     r_key;
    logic [VAL_W-1:0]     r_value;
    logic [IDX_W-1:0]     r_addr;
    logic                 r_issue;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [STAMP_W-1:0]   r_touch;
    logic [MAX_ENTRIES-1:0] r_valid;

    // entry memory
    logic [WORD_W-1:0]    mem [MAX_ENTRIES];
    logic [WORD_W-1:0]    r_rd_data;

    // output register
    logic                 r_out_valid;
    logic                 r_hit;
    logic [VAL_W-1:0]     r_read_value;
    logic                 r_evicted;
    logic [KEY_W-1:0]     r_evicted_key;

    // scan results
    t_scan_flags          scan_flags;
    logic [IDX_W-1:0]     match_idx;
    logic [VAL_W-1:0]     match_value;
    logic [COUNT_BITS-1:0] match_count;
    logic [IDX_W-1:0]     best_idx;
    logic [KEY_W-1:0]     best_key;
    logic [IDX_W-1:0]     free_idx;
    logic [USED_W-1:0]    used;

    // control and write-back decision
    logic                 in_accept;
    logic                 out_free;
    logic                 rd_en;
    logic                 wb_fire;
    logic                 mem_we;
    logic                 scan_last;
    logic [CMP_W-1:0]     cap_ext;
    logic [CMP_W-1:0]     cap_eff;
    logic                 cap_zero;
    logic                 full;
    logic                 wb_write;
    logic                 wb_insert;
    logic [IDX_W-1:0]     wb_idx;
    logic [VAL_W-1:0]     wb_value;
    logic [COUNT_BITS-1:0] wb_count;
    logic [WORD_W-1:0]    wb_word;
    logic                 res_hit;
    logic [VAL_W-1:0]     res_read_value;
    logic                 res_evicted;
    logic [KEY_W-1:0]     res_evicted_key;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign scan_last = r_rd_vld && (r_rd_idx == LAST_IDX);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN: if (scan_last) n_state = ST_WB;
            ST_WB:   if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        wb_fire    = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_SCAN: rd_en = r_issue;
            ST_WB:   wb_fire = out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_type <= i_req_type;
            r_key      <= i_key;
            r_value    <= i_value;
        end
    end

    // read address sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_rd_vld <= rd_en;
            if (in_accept) begin
                r_issue <= 1'b1;
                r_addr  <= '0;
            end else if (rd_en) begin
                if (r_addr == LAST_IDX) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_idx <= r_addr;
    end

    // entry memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= mem[r_addr];
        if (mem_we) mem[wb_idx] <= wb_word;
    end

    // scan datapath
    lfu_scan #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (in_accept),
        .i_elem_vld      (r_rd_vld),
        .i_elem_idx      (r_rd_idx),
        .i_entry_valid   (r_valid[r_rd_idx]),
        .i_entry_key     (r_rd_data[KEY_LSB +: KEY_W]),
        .i_entry_value   (r_rd_data[VALUE_LSB +: VAL_W]),
        .i_entry_count   (r_rd_data[COUNT_LSB +: COUNT_BITS]),
        .i_entry_stamp   (r_rd_data[STAMP_LSB +: STAMP_W]),
        .i_key           (r_key),
        .i_touch_counter (r_touch),
        .o_flags         (scan_flags),
        .o_match_idx     (match_idx),
        .o_match_value   (match_value),
        .o_match_count   (match_count),
        .o_best_idx      (best_idx),
        .o_best_key      (best_key),
        .o_free_idx      (free_idx),
        .o_used          (used)
    );

    // effective capacity and fullness
    always_comb begin
        cap_ext  = CMP_W'(r_cap);
        cap_eff  = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;
        cap_zero = (r_cap == '0);
        full     = (CMP_W'(used) >= cap_eff);
    end

    // write-back decision and result
    always_comb begin
        res_hit         = 1'b0;
        res_read_value  = '0;
        res_evicted     = 1'b0;
        res_evicted_key = '0;
        wb_write        = 1'b0;
        wb_insert       = 1'b0;
        wb_idx          = match_idx;
        wb_value        = r_value;
        if (r_req_type == REQ_GET) begin
            if (scan_flags.match_found) begin
                res_hit        = 1'b1;
                res_read_value = match_value;
                wb_write       = 1'b1;
                wb_value       = match_value;
            end
        end else if (!cap_zero) begin
            if (scan_flags.match_found) begin
                res_hit  = 1'b1;
                wb_write = 1'b1;
            end else if (full) begin
                if (scan_flags.best_found) begin
                    res_evicted     = 1'b1;
                    res_evicted_key = best_key;
                    wb_write        = 1'b1;
                    wb_insert       = 1'b1;
                    wb_idx          = best_idx;
                end
            end else if (scan_flags.free_found) begin
                wb_write  = 1'b1;
                wb_insert = 1'b1;
                wb_idx    = free_idx;
            end
        end
    end

    // new entry contents, count saturates
    always_comb begin
        if (wb_insert) begin
            wb_count = COUNT_BITS'(1);
        end else if (match_count == '1) begin
            wb_count = match_count;
        end else begin
            wb_count = match_count + COUNT_BITS'(1);
        end
        wb_word = '0;
        wb_word[KEY_LSB +: KEY_W]        = r_key;
        wb_word[VALUE_LSB +: VAL_W]      = wb_value;
        wb_word[COUNT_LSB +: COUNT_BITS] = wb_count;
        wb_word[STAMP_LSB +: STAMP_W]    = r_touch;
    end

    assign mem_we = wb_fire && wb_write;

    // valid bits and touch counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_touch <= '0;
        end else if (mem_we) begin
            r_touch <= r_touch + STAMP_W'(1);
            if (wb_insert) r_valid[wb_idx] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_fire) begin
            r_hit         <= res_hit;
            r_read_value  <= res_read_value;
            r_evicted     <= res_evicted;
            r_evicted_key <= res_evicted_key;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

    // a transaction appears only after a write-back cycle
    a_out_after_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_WB)
        else $error("result raised outside write-back");

    // no memory reads in flight while idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_rd_vld && !r_issue))
        else $error("scan activity while idle");

    // touch counter moves only with a memory write
    a_touch_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_touch != $past(r_touch))) |-> $past(mem_we))
        else $error("touch counter moved without write-back");

    // an eviction never goes with a hit
    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted) |-> !o_hit)
        else $error("eviction reported on a hit");

endmodule

### sv/lfu_scan.sv
// ----------------------------------------------------------------------------
// lfu_scan
// Walks the table one entry per cycle as the memory returns it: finds the
// matching key, the eviction victim (lowest count, oldest touch, lowest
// index), the first free slot and the number of occupied entries.
// ----------------------------------------------------------------------------
module lfu_scan #(
    parameter int   MAX_ENTRIES = lfu_pkg::LFU_MAX_ENTRIES,
    parameter int   COUNT_BITS  = lfu_pkg::LFU_COUNT_BITS,
    localparam int  IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int  USED_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_elem_vld,
    input  logic [IDX_W-1:0]              i_elem_idx,
    input  logic                          i_entry_valid,
    input  logic [lfu_pkg::KEY_W-1:0]     i_entry_key,
    input  logic [lfu_pkg::VAL_W-1:0]     i_entry_value,
    input  logic [COUNT_BITS-1:0]         i_entry_count,
    input  logic [lfu_pkg::STAMP_W-1:0]   i_entry_stamp,
    input  logic [lfu_pkg::KEY_W-1:0]     i_key,
    input  logic [lfu_pkg::STAMP_W-1:0]   i_touch_counter,
    output lfu_pkg::t_scan_flags          o_flags,
    output logic [IDX_W-1:0]              o_match_idx,
    output logic [lfu_pkg::VAL_W-1:0]     o_match_value,
    output logic [COUNT_BITS-1:0]         o_match_count,
    output logic [IDX_W-1:0]              o_best_idx,
    output logic [lfu_pkg::KEY_W-1:0]     o_best_key,
    output logic [IDX_W-1:0]              o_free_idx,
    output logic [USED_W-1:0]             o_used
);
    import lfu_pkg::*;

    t_scan_flags           r_flags;
    logic [IDX_W-1:0]      r_match_idx;
    logic [VAL_W-1:0]      r_match_value;
    logic [COUNT_BITS-1:0] r_match_count;
    logic [IDX_W-1:0]      r_best_idx;
    logic [KEY_W-1:0]      r_best_key;
    logic [COUNT_BITS-1:0] r_best_count;
    logic [STAMP_W-1:0]    r_best_age;
    logic [IDX_W-1:0]      r_free_idx;
    logic [USED_W-1:0]     r_used;

    logic                  is_match;
    logic                  is_better;
    logic                  is_free;
    logic [STAMP_W-1:0]    age;

    // per-entry compare
    always_comb begin
        age      = i_touch_counter - i_entry_stamp;
        is_match = i_elem_vld && i_entry_valid && (i_entry_key == i_key)
                   && !r_flags.match_found;
        is_free  = i_elem_vld && !i_entry_valid && !r_flags.free_found;
        is_better = i_elem_vld && i_entry_valid &&
                    (!r_flags.best_found || (i_entry_count < r_best_count) ||
                     ((i_entry_count == r_best_count) && (age > r_best_age)));
    end

    // found flags and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_flags <= '0;
            r_used  <= '0;
        end else begin
            if (is_match)  r_flags.match_found <= 1'b1;
            if (is_better) r_flags.best_found  <= 1'b1;
            if (is_free)   r_flags.free_found  <= 1'b1;
            if (i_elem_vld && i_entry_valid) r_used <= r_used + USED_W'(1);
        end
    end

    // captured entry data
    always_ff @(posedge i_clk) begin
        if (is_match) begin
            r_match_idx   <= i_elem_idx;
            r_match_value <= i_entry_value;
            r_match_count <= i_entry_count;
        end
        if (is_better) begin
            r_best_idx   <= i_elem_idx;
            r_best_key   <= i_entry_key;
            r_best_count <= i_entry_count;
            r_best_age   <= age;
        end
        if (is_free) r_free_idx <= i_elem_idx;
    end

    assign o_flags       = r_flags;
    assign o_match_idx   = r_match_idx;
    assign o_match_value = r_match_value;
    assign o_match_count = r_match_count;
    assign o_best_idx    = r_best_idx;
    assign o_best_key    = r_best_key;
    assign o_free_idx    = r_free_idx;
    assign o_used        = r_used;

endmodule
